@@ design/skl_pkg.sv @@
// Shared types and constants for the sorted key list block.
// Holds the request and result payload structs, status codes and cell commands.
// No dependencies.
package skl_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned CAPACITY_MAX = 64;

  // Request codes; code 3 is ignored by the block
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LIST   = 2'd2
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_ENTRY     = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    req_type_e        req_type;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] entry_key;
    logic             last;
  } out_item_t;

endpackage

@@ design/skl_cell.sv @@
// One storage cell of the sorted key chain.
// Holds a key, compares it with the request key and trades keys with its neighbors.
// Depends on skl_pkg.
module skl_cell #(
  parameter int unsigned Capacity = skl_pkg::CAPACITY_DEF,
  parameter int unsigned Idx      = 0,
  localparam int unsigned CntW    = $clog2(Capacity + 1)
) (
  input  logic                    clk_i,
  input  skl_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CntW-1:0]         count_i,
  input  logic [skl_pkg::KEY_W-1:0] left_key_i,
  input  logic                    left_gt_i,
  input  logic [skl_pkg::KEY_W-1:0] right_key_i,
  input  logic [skl_pkg::KEY_W-1:0] head_key_i,
  output logic [skl_pkg::KEY_W-1:0] key_o,
  output logic                    gt_o,
  output logic                    eq_o
);
  import skl_pkg::*;

  localparam logic [CntW-1:0] IdxC  = CntW'(Idx);
  localparam logic [CntW-1:0] NextC = CntW'(Idx + 1);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occ;
  logic             ge;

  // Compare against the request key; only occupied cells take part
  assign occ  = IdxC < count_i;
  assign gt_o = occ && (key_q > ctrl_i.key);
  assign ge   = occ && (key_q >= ctrl_i.key);
  assign eq_o = occ && (key_q == ctrl_i.key);

  // Next key: open a gap on insert, close it on delete, rotate on list
  always_comb begin
    key_d = key_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (left_gt_i) begin
          key_d = left_key_i;
        end else if (gt_o || (IdxC == count_i)) begin
          key_d = ctrl_i.key;
        end
      end
      CMD_DELETE: begin
        if (ge && (NextC < count_i)) begin
          key_d = right_key_i;
        end
      end
      CMD_ROTATE: begin
        if (NextC < count_i) begin
          key_d = right_key_i;
        end else if (NextC == count_i) begin
          key_d = head_key_i;
        end
      end
      CMD_HOLD: begin
        key_d = key_q;
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ design/sorted_key_list_core.sv @@
// Sorted key list: insert and delete update the whole cell chain at once, and the
// result is registered, so its transfer comes in the cycle after the request transfer
// at the earliest; an insert or delete is taken every cycle that the output is free.
// A list request streams one key per cycle that the output is free, from the head of
// the chain as it rotates once, and holds the input until its last key is registered.
// Reset (rst_ni low, asynchronous) empties the list; key storage is not cleared.
module sorted_key_list_core #(
  parameter int unsigned Capacity = skl_pkg::CAPACITY_DEF,
  localparam int unsigned CntW    = $clog2(Capacity + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output skl_pkg::out_item_t out_data_o
);
  import skl_pkg::*;

  localparam logic [CntW-1:0] CapC = CntW'(Capacity);
  localparam logic [CntW-1:0] OneC = CntW'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  cell_ctrl_t       ctrl;
  logic [KEY_W-1:0] cell_key [Capacity];
  logic [Capacity-1:0] gt_vec;
  logic [Capacity-1:0] eq_vec;
  logic             out_free;
  logic             accept;
  logic             found;
  logic             full;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign found      = |eq_vec;
  assign full       = count_q == CapC;

  // Cell chain
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    logic             left_gt;
    if (i == 0) begin : g_head
      assign left_key = cell_key[0];
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_gt  = gt_vec[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end
    skl_cell #(
      .Capacity(Capacity),
      .Idx     (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .left_key_i (left_key),
      .left_gt_i  (left_gt),
      .right_key_i(right_key),
      .head_key_i (cell_key[0]),
      .key_o      (cell_key[i]),
      .gt_o       (gt_vec[i]),
      .eq_o       (eq_vec[i])
    );
  end

  // Control: chain command, count, list progress and the result register
  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.key    = in_data_i.key;
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_LIST: begin
        if (out_free) begin
          ctrl.cmd    = CMD_ROTATE;
          out_valid_d = 1'b1;
          out_data_d  = '{status: STAT_ENTRY, entry_key: cell_key[0], last: rem_q == OneC};
          rem_d       = rem_q - OneC;
          if (rem_q == OneC) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.req_type)
            REQ_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_data_d = '{status: STAT_FULL, entry_key: '0, last: 1'b1};
              end else begin
                ctrl.cmd   = CMD_INSERT;
                count_d    = count_q + OneC;
                out_data_d = '{status: STAT_DONE, entry_key: '0, last: 1'b1};
              end
            end
            REQ_DELETE: begin
              out_valid_d = 1'b1;
              if (found) begin
                ctrl.cmd   = CMD_DELETE;
                count_d    = count_q - OneC;
                out_data_d = '{status: STAT_DONE, entry_key: '0, last: 1'b1};
              end else begin
                out_data_d = '{status: STAT_NOT_FOUND, entry_key: '0, last: 1'b1};
              end
            end
            REQ_LIST: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                out_data_d = '{status: STAT_EMPTY, entry_key: '0, last: 1'b1};
              end else begin
                ctrl.cmd   = CMD_ROTATE;
                out_data_d = '{status: STAT_ENTRY, entry_key: cell_key[0],
                               last: count_q == OneC};
                rem_d      = count_q - OneC;
                if (count_q != OneC) begin
                  state_d = ST_LIST;
                end
              end
            end
            default: begin
              // unused request code: no result
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("key count above capacity");

  a_list_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (rem_q != '0))
    else $error("list streaming with nothing left");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.req_type == REQ_INSERT) && !full)
      |=> (count_q == CntW'($past(count_q) + OneC)))
    else $error("insert did not grow the list");

  a_list_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.req_type == REQ_LIST) && (count_q != '0))
      |=> (out_valid_q && (out_data_q.status == STAT_ENTRY)))
    else $error("list did not emit first entry");
`endif

endmodule

@@ bench/skl_list_checker.sv @@
// Channel monitor and scoreboard for the sorted key list core.
// Keeps a shadow copy of the sorted store, predicts results per request transfer
// and compares each result transfer in order. Depends on skl_pkg.
module skl_list_checker #(
  parameter int unsigned Capacity = skl_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  skl_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  skl_pkg::out_item_t out_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  // Results still owed by the block, oldest first
  out_item_t        expected_results [$];
  // Shadow of the list contents, only entries below stored_count are meaningful
  logic [KEY_W-1:0] stored_keys [0:Capacity-1];
  int               stored_count = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void push_result(input status_e status, input logic [KEY_W-1:0] entry_key,
                                      input logic last);
    out_item_t item;
    item.status    = status;
    item.entry_key = entry_key;
    item.last      = last;
    expected_results.push_back(item);
  endfunction

  // Apply one request to the shadow list and queue the results it produces
  function automatic void apply_request(input in_item_t req);
    int pos;
    pos = stored_count;
    case (req.req_type)
      REQ_INSERT: begin
        if (stored_count >= int'(Capacity)) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          // goes ahead of the first strictly greater key, so equals keep arrival order
          for (int i = 0; i < stored_count; i++) begin
            if (stored_keys[i] > req.key) begin
              pos = i;
              break;
            end
          end
          for (int i = stored_count; i > pos; i--) stored_keys[i] = stored_keys[i-1];
          stored_keys[pos] = req.key;
          stored_count++;
          push_result(STAT_DONE, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        for (int i = 0; i < stored_count; i++) begin
          if (stored_keys[i] == req.key) begin
            pos = i;
            break;
          end
        end
        if (pos == stored_count) begin
          push_result(STAT_NOT_FOUND, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < stored_count; i++) stored_keys[i] = stored_keys[i+1];
          stored_count--;
          push_result(STAT_DONE, '0, 1'b1);
        end
      end
      REQ_LIST: begin
        if (stored_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            push_result(STAT_ENTRY, stored_keys[i], (i + 1 == stored_count));
          end
        end
      end
      default: ; // unused request code: no state change, no result
    endcase
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin : monitor_blk
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $error("unexpected result transfer: status %0d entry_key %h last %0b",
                 got.status, got.entry_key, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            fail_count_o++;
            $error("status: expected %0d, actual %0d", want.status, got.status);
          end
          if (got.entry_key !== want.entry_key) begin
            fail_count_o++;
            $error("entry_key: expected %h, actual %h", want.entry_key, got.entry_key);
          end
          if (got.last !== want.last) begin
            fail_count_o++;
            $error("last: expected %0b, actual %0b", want.last, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
      pending_o = expected_results.size();
    end
  end

endmodule

@@ bench/sorted_key_list_core_tb.sv @@
// Top of the sorted key list core testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on skl_pkg, sorted_key_list_core
// and skl_list_checker.
module sorted_key_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  localparam int unsigned RandomItems = 480;
  localparam int unsigned QuietItems  = 60;   // tail of the run with no idling
  localparam int unsigned HoldAfter   = 150;  // requests sent before the long stall
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 64;   // longer than a full list stream
  // worst case 499 requests x 32 results with stall bursts, plus gaps and the hold
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned PoolSize    = 16;
  localparam logic [REQ_W-1:0] ReqUnused = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  int unsigned      fail_count;
  int unsigned      pending_count;
  int unsigned      sent_count = 0;
  int unsigned      cycle_count = 0;
  bit               quiet_phase = 1'b0;
  logic [KEY_W-1:0] key_pool [0:PoolSize-1];

  sorted_key_list_core #(
    .Capacity(CAPACITY_DEF)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  skl_list_checker #(
    .Capacity(CAPACITY_DEF)
  ) u_list_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Text id of 1 to 4 lowercase letters, packed big-endian, zero padded
  function automatic logic [KEY_W-1:0] text_key(input int unsigned len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < 4; b++) begin
      k = k << 8;
      if (b < len) k[7:0] = 8'h61 + 8'($urandom_range(0, 25));
    end
    return k;
  endfunction

  // Pool keys make deletes hit and duplicates common; the rest is noise
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return key_pool[$urandom_range(0, PoolSize - 1)];
    if (roll < 75) return text_key($urandom_range(1, 4));
    if (roll < 78) return '0;
    if (roll < 81) return '1;
    return $urandom;
  endfunction

  // One request transfer, with an optional idle burst ahead of it
  task automatic send_request(input logic [REQ_W-1:0] code, input logic [KEY_W-1:0] key);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_data.req_type <= req_type_e'(code);
    in_data.key      <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Result side: random stall bursts, calm stretches and one long hold
  initial begin : result_sink
    int unsigned stall_left;
    bit          calm;
    bit          long_hold_done;
    stall_left     = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    out_ready      = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (stall_left == 0) begin
        if (!long_hold_done && sent_count >= HoldAfter) begin
          long_hold_done = 1'b1;
          stall_left     = HoldCycles;
        end else if (!quiet_phase && !calm && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_key_list_core: mismatch");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned      insert_pct;
    int unsigned      roll;
    logic [REQ_W-1:0] code;
    insert_pct = 50;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = (i < 12) ? text_key($urandom_range(1, 4)) : $urandom;
    end

    // Directed: empty list cases, extremes, duplicates, embedded zero bytes
    send_request(REQ_LIST, '0);
    send_request(REQ_DELETE, 32'h6162_6300);
    send_request(ReqUnused, '1);
    send_request(REQ_INSERT, 32'h6D69_6B65);
    send_request(REQ_INSERT, 32'h0000_0000);
    send_request(REQ_INSERT, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h6D69_6B65);  // equal to a middle key
    send_request(REQ_INSERT, 32'hFFFF_FFFF);  // equal to the tail
    send_request(REQ_INSERT, 32'h6162_0000);
    send_request(REQ_INSERT, 32'h6100_6200);  // zero byte inside the key
    send_request(REQ_INSERT, 32'h6100_0000);
    send_request(REQ_LIST, '1);
    send_request(ReqUnused, '0);
    send_request(REQ_DELETE, 32'h6D69_6B65);
    send_request(REQ_DELETE, 32'h1234_5678);
    send_request(REQ_DELETE, 32'h0000_0000);  // head
    send_request(REQ_DELETE, 32'hFFFF_FFFF);  // one of the two tails
    send_request(REQ_DELETE, 32'h6100_0062);  // near miss of the embedded-zero key
    send_request(REQ_LIST, 32'h5555_5555);

    // Random: phases that grow, balance and shrink the list to reach full and empty
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ((n / 40) % 4)
          0:       insert_pct = 70;
          1:       insert_pct = 45;
          2:       insert_pct = 20;
          default: insert_pct = $urandom_range(20, 70);
        endcase
      end
      if (n == RandomItems - QuietItems) quiet_phase = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3)                    code = ReqUnused;
      else if (roll < 15)              code = REQ_LIST;
      else if (roll < 15 + insert_pct) code = REQ_INSERT;
      else                             code = REQ_DELETE;
      send_request(code, pick_key());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("sorted_key_list_core: match");
    end else begin
      $display("sorted_key_list_core: mismatch");
    end
    $finish;
  end

endmodule
